// ----- design/eosd_pkg.sv -----
// ----------------------------------------------------------------------------
// eosd_pkg
// Types and constants shared by the edit-op record stream decoder.
// ----------------------------------------------------------------------------
package eosd_pkg;

	localparam int unsigned MaxRes = 4;
	localparam int unsigned QueueDepth = 4;

	// field codes
	localparam logic [4:0] FC_TAG        = 5'd0;
	localparam logic [4:0] FC_ID_COUNT   = 5'd1;
	localparam logic [4:0] FC_ID_BRANCH  = 5'd2;
	localparam logic [4:0] FC_ID_NUMBER  = 5'd3;
	localparam logic [4:0] FC_AT         = 5'd4;
	localparam logic [4:0] FC_START      = 5'd5;
	localparam logic [4:0] FC_LENGTH     = 5'd6;
	localparam logic [4:0] FC_SCROLL     = 5'd7;
	localparam logic [4:0] FC_TO         = 5'd8;
	localparam logic [4:0] FC_SRC_AT     = 5'd9;
	localparam logic [4:0] FC_SRC_LENGTH = 5'd10;
	localparam logic [4:0] FC_LINK       = 5'd11;
	localparam logic [4:0] FC_SRC_OFS    = 5'd11;
	localparam logic [4:0] FC_DONE       = 5'd16;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_TRUNC     = 3'd1;
	localparam logic [2:0] ERR_KIND      = 3'd2;
	localparam logic [2:0] ERR_LONG      = 3'd3;
	localparam logic [2:0] ERR_SEGMENTS  = 3'd4;

	// parse phases
	localparam logic [4:0] P_TAG        = 5'd0;
	localparam logic [4:0] P_ID_COUNT   = 5'd1;
	localparam logic [4:0] P_ID_BRANCH  = 5'd2;
	localparam logic [4:0] P_ID_BR_EXT  = 5'd3;
	localparam logic [4:0] P_ID_NUMBER  = 5'd4;
	localparam logic [4:0] P_SRC_PH_OFS = 5'd4;
	localparam logic [4:0] P_OPER0      = 5'd9;

	localparam logic [3:0] KIND_INSERT = 4'd0;
	localparam logic [3:0] KIND_DELETE = 4'd1;
	localparam logic [3:0] KIND_INT_TR = 4'd3;
	localparam logic [3:0] NUM_KINDS   = 4'd7;

	localparam logic [63:0] MAX_SEGMENTS = 64'd4096;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  field_code;
		logic [63:0] field_value;
		logic [3:0]  op_kind;
		logic        sequential_flag;
		logic        record_last;
		logic [2:0]  error_code;
	} out_item_t;

	// one step's result bundle pushed into the queue
	typedef struct packed {
		logic [2:0]                   count;
		out_item_t [MaxRes-1:0]       res;
	} res_group_t;

	function automatic logic [4:0] kind_code(input logic [3:0] kind, input logic [1:0] slot);
		logic [4:0] c;
		c = 5'd0;
		case (kind)
			4'd0: case (slot)
				2'd0: c = FC_AT;
				2'd1: c = FC_START;
				2'd2: c = FC_LENGTH;
				default: c = FC_SCROLL;
			endcase
			4'd1: c = (slot == 2'd0) ? FC_AT : FC_LENGTH;
			4'd2: c = (slot == 2'd0) ? FC_AT : (slot == 2'd1) ? FC_LENGTH : FC_TO;
			4'd3: c = (slot == 2'd0) ? FC_AT : (slot == 2'd1) ? FC_SRC_AT : FC_SRC_LENGTH;
			4'd4: case (slot)
				2'd0: c = FC_AT;
				2'd1: c = FC_SCROLL;
				2'd2: c = FC_START;
				default: c = FC_LENGTH;
			endcase
			4'd5: c = FC_LINK;
			4'd6: c = FC_AT;
			default: c = 5'd0;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] kind_len(input logic [3:0] kind);
		logic [2:0] n;
		case (kind)
			4'd0: n = 3'd4;
			4'd1: n = 3'd2;
			4'd2: n = 3'd3;
			4'd3: n = 3'd3;
			4'd4: n = 3'd4;
			4'd5: n = 3'd1;
			4'd6: n = 3'd1;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

// ----- design/eosd_stream_if.sv -----
// ----------------------------------------------------------------------------
// eosd_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface eosd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/edit_op_record_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// edit_op_record_stream_decoder
// Decodes a byte stream of edit-operation records into one result per field.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue has room; a byte yields up
// to four results, and the output sends one per cycle while out_ch.ready is
// high, so sustained rate is set by the output queue.
// Queue: four result groups between the parser and the output serializer.
// Reset: arst_n clears parse state, halt flag, queue and the scroll register.
module edit_op_record_stream_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata,
	eosd_stream_if.sink          in_ch,
	eosd_stream_if.source        out_ch
);
	import eosd_pkg::*;

	logic [31:0] scroll_q;      // local scroll id register
	logic        grp_valid;
	logic        grp_room;
	res_group_t  grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scroll_q <= '0;
		else if (cfg_we) scroll_q <= cfg_wdata;
	end

	// front: parse one byte per transfer into a result group
	eosd_front u_front (
		.clk, .arst_n,
		.local_scroll_id(scroll_q),
		.in_valid(in_ch.valid),
		.in_item(in_ch.payload),
		.in_ready(in_ch.ready),
		.grp_valid, .grp, .grp_room
	);

	// back: queue the groups and send results one at a time
	eosd_back u_back (
		.clk, .arst_n,
		.grp_valid, .grp, .grp_room,
		.out_ch
	);

endmodule

// ----- design/eosd_front.sv -----
// ----------------------------------------------------------------------------
// eosd_front
// Parser: takes one byte per transfer and builds the results it causes.
// ----------------------------------------------------------------------------
module eosd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           local_scroll_id,
	input  logic                  in_valid,
	input  eosd_pkg::in_item_t    in_item,
	output logic                  in_ready,
	output logic                  grp_valid,
	output eosd_pkg::res_group_t  grp,
	input  logic                  grp_room
);
	import eosd_pkg::*;

	logic [4:0]  phase_q;
	logic [7:0]  tag_q;
	logic [63:0] acc_q;
	logic [3:0]  vidx_q;
	logic [12:0] seg_q;
	logic        halted_q;

	logic [4:0]  phase_d;
	logic [7:0]  tag_d;
	logic [63:0] acc_d;
	logic [3:0]  vidx_d;
	logic [12:0] seg_d;
	logic        halted_d;
	res_group_t  g;

	logic        fire;
	assign in_ready  = grp_room;
	assign fire      = in_valid && grp_room;
	assign grp_valid = fire && !halted_q;
	assign grp       = g;

	always_comb begin
		logic [7:0]  b;
		logic [3:0]  idx;
		logic [63:0] acc_n;
		logic [63:0] v;
		logic        vdone;
		logic        vlong;
		logic        src;
		logic [4:0]  ph;
		logic [4:0]  base;
		logic [3:0]  kind;
		logic [1:0]  slot;
		logic [4:0]  code;
		logic        adv;
		logic [2:0]  adv_slot;
		logic [63:0] adv_at;
		logic        stop;
		logic        kfail;
		logic [2:0]  n;
		logic [12:0] segm;

		b = in_item.in_byte;
		phase_d = phase_q; tag_d = tag_q; acc_d = acc_q; vidx_d = vidx_q;
		seg_d = seg_q; halted_d = halted_q;
		g = '0;
		n = 3'd0;
		adv = 1'b0; adv_slot = 3'd0; adv_at = '0; kfail = 1'b0;
		stop = 1'b0;
		kind = tag_q[3:0];
		slot = 2'd0; code = 5'd0; src = 1'b0; base = 5'd0; ph = phase_q;
		segm = seg_q - 13'd1;

		// shared varint step
		idx = (vidx_q > 4'd9) ? 4'd9 : vidx_q;
		acc_n = acc_q | ({57'd0, b[6:0]} << (7 * idx));
		vlong = b[7] && (idx >= 4'd9);
		vdone = !b[7];
		v = acc_n;

		if (in_item.stream_end) begin
			g.res[0].field_code = FC_DONE;
			g.res[0].error_code = (phase_q == P_TAG) ? ERR_NONE : ERR_TRUNC;
			n = 3'd1;
			halted_d = 1'b1;
		end else if (phase_q >= P_OPER0) begin
			slot = 2'(phase_q - P_OPER0);
			if (kind >= NUM_KINDS || {1'b0, slot} >= kind_len(kind)) begin
				kfail = 1'b1;
			end else if (vlong) begin
				g.res[0].field_code = FC_DONE;
				g.res[0].error_code = ERR_LONG;
				n = 3'd1;
				halted_d = 1'b1;
			end else if (!vdone) begin
				acc_d = acc_n; vidx_d = idx + 4'd1;
			end else begin
				acc_d = '0; vidx_d = '0;
				code = kind_code(kind, slot);
				if (code == FC_AT || code == FC_LENGTH || code == FC_TO ||
				    code == FC_SRC_AT || code == FC_SRC_LENGTH)
					v = {32'd0, acc_n[31:0]};
				g.res[0].field_code = code;
				g.res[0].field_value = v;
				n = 3'd1;
				if (kind == KIND_INT_TR && slot == 2'd0)
					phase_d = P_ID_COUNT + P_SRC_PH_OFS;
				else begin
					adv = 1'b1; adv_slot = {1'b0, slot} + 3'd1; adv_at = v;
				end
			end
		end else if (phase_q == P_TAG || phase_q > P_ID_NUMBER + P_SRC_PH_OFS) begin
			tag_d = b;
			kind = b[3:0];
			g.res[0].field_code = FC_TAG;
			g.res[0].field_value = {56'd0, b};
			n = 3'd1;
			if (!b[4]) phase_d = P_ID_COUNT;
			else if (kind >= NUM_KINDS) kfail = 1'b1;
			else begin adv = 1'b1; adv_slot = 3'd0; end
		end else begin
			src = phase_q > P_ID_NUMBER;
			base = src ? FC_SRC_OFS : 5'd0;
			ph = src ? phase_q - P_SRC_PH_OFS : phase_q;
			if (ph == P_ID_BRANCH) begin
				if (b == 8'd255) phase_d = P_ID_BR_EXT + (src ? P_SRC_PH_OFS : 5'd0);
				else begin
					g.res[0].field_code = base + FC_ID_BRANCH;
					g.res[0].field_value = {56'd0, b};
					n = 3'd1;
					phase_d = P_ID_NUMBER + (src ? P_SRC_PH_OFS : 5'd0);
				end
			end else if (vlong) begin
				g.res[0].field_code = FC_DONE;
				g.res[0].error_code = ERR_LONG;
				n = 3'd1;
				halted_d = 1'b1;
			end else if (!vdone) begin
				acc_d = acc_n; vidx_d = idx + 4'd1;
			end else begin
				acc_d = '0; vidx_d = '0;
				if (ph == P_ID_COUNT) begin
					if (acc_n > MAX_SEGMENTS) begin
						g.res[0].field_code = FC_DONE;
						g.res[0].error_code = ERR_SEGMENTS;
						n = 3'd1;
						halted_d = 1'b1;
					end else begin
						g.res[0].field_code = base + FC_ID_COUNT;
						g.res[0].field_value = acc_n;
						n = 3'd1;
						seg_d = acc_n[12:0];
						if (acc_n == 64'd0) begin
							if (src) begin adv = 1'b1; adv_slot = 3'd1; end
							else if (kind >= NUM_KINDS) kfail = 1'b1;
							else begin adv = 1'b1; adv_slot = 3'd0; end
						end else phase_d = P_ID_BRANCH + (src ? P_SRC_PH_OFS : 5'd0);
					end
				end else begin
					g.res[0].field_code = (ph == P_ID_BR_EXT) ? base + FC_ID_BRANCH
					                                         : base + FC_ID_NUMBER;
					g.res[0].field_value = {32'd0, acc_n[31:0]};
					n = 3'd1;
					if (ph == P_ID_BR_EXT)
						phase_d = P_ID_NUMBER + (src ? P_SRC_PH_OFS : 5'd0);
					else begin
						seg_d = segm;
						if (segm == 13'd0) begin
							if (src) begin adv = 1'b1; adv_slot = 3'd1; end
							else if (kind >= NUM_KINDS) kfail = 1'b1;
							else begin adv = 1'b1; adv_slot = 3'd0; end
						end else phase_d = P_ID_BRANCH + (src ? P_SRC_PH_OFS : 5'd0);
					end
				end
			end
		end

		// default-field walk: at most four slots, independent of byte
		if (adv) begin
			for (int s = 0; s < 4; s++) begin
				if (!stop && 3'(s) >= adv_slot && 3'(s) < kind_len(kind)) begin
					code = kind_code(kind, 2'(s));
					if ((kind == KIND_INSERT && ((code == FC_START && tag_d[6]) ||
					     (code == FC_LENGTH && tag_d[7]) ||
					     (code == FC_SCROLL && tag_d[5]))) ||
					    (kind == KIND_DELETE && code == FC_LENGTH && tag_d[7])) begin
						if (n < 3'(MaxRes)) begin
							g.res[n[1:0]].field_code = code;
							g.res[n[1:0]].field_value = (code == FC_START) ? adv_at :
								(code == FC_LENGTH) ? 64'd1 : {32'd0, local_scroll_id};
							n = n + 3'd1;
						end
					end else begin
						stop = 1'b1;
						phase_d = P_OPER0 + 5'(s);
					end
				end
			end
			if (!stop) begin
				if (n != 3'd0) g.res[n[1:0] - 2'd1].record_last = 1'b1;
				phase_d = P_TAG;
			end
		end
		if (kfail) begin
			if (n < 3'(MaxRes)) begin
				g.res[n[1:0]].field_code = FC_DONE;
				g.res[n[1:0]].error_code = ERR_KIND;
				n = n + 3'd1;
			end
			halted_d = 1'b1;
		end
		for (int i = 0; i < MaxRes; i++) begin
			g.res[i].op_kind = tag_d[3:0];
			g.res[i].sequential_flag = tag_d[4];
		end
		g.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_TAG; tag_q <= '0; acc_q <= '0; vidx_q <= '0;
			seg_q <= '0; halted_q <= 1'b0;
		end else if (fire && !halted_q) begin
			phase_q <= phase_d; tag_q <= tag_d; acc_q <= acc_d; vidx_q <= vidx_d;
			seg_q <= seg_d; halted_q <= halted_d;
		end
	end

	property p_halt_sticky;
		@(posedge clk) disable iff (!arst_n) halted_q |=> halted_q;
	endproperty
	a_halt_sticky: assert property (p_halt_sticky) else $error("halt cleared");

	property p_idx_range;
		@(posedge clk) disable iff (!arst_n) vidx_q <= 4'd9;
	endproperty
	a_idx_range: assert property (p_idx_range) else $error("varint index overflow");

	property p_no_push_halted;
		@(posedge clk) disable iff (!arst_n) halted_q |-> !grp_valid;
	endproperty
	a_no_push_halted: assert property (p_no_push_halted) else $error("push after halt");

endmodule

// ----- design/eosd_back.sv -----
// ----------------------------------------------------------------------------
// eosd_back
// Result queue and serializer: holds result groups, sends one result per transfer.
// ----------------------------------------------------------------------------
module eosd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  grp_valid,
	input  eosd_pkg::res_group_t  grp,
	output logic                  grp_room,
	eosd_stream_if.source         out_ch
);
	import eosd_pkg::*;

	localparam int unsigned AW = $clog2(QueueDepth);

	res_group_t     mem_q [QueueDepth];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	logic [1:0]     sub_q;
	logic           push, pop, last_sub;
	res_group_t     head;

	assign head     = mem_q[rd_q];
	assign push     = grp_valid && grp.count != 3'd0;
	// room from the count alone, so output ready never reaches input ready
	assign grp_room = cnt_q < (AW+1)'(QueueDepth);
	assign out_ch.valid   = cnt_q != '0;
	assign out_ch.payload = head.res[sub_q];
	assign last_sub = ({1'b0, sub_q} + 3'd1) == head.count;
	assign pop = out_ch.valid && out_ch.ready && last_sub;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0; sub_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop) rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
			if (out_ch.valid && out_ch.ready) sub_q <= last_sub ? 2'd0 : sub_q + 2'd1;
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) cnt_q <= (AW+1)'(QueueDepth);
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

	property p_sub_reset;
		@(posedge clk) disable iff (!arst_n) pop |=> sub_q == 2'd0;
	endproperty
	a_sub_reset: assert property (p_sub_reset) else $error("sub index not cleared");

	property p_push_room;
		@(posedge clk) disable iff (!arst_n) push |-> grp_room;
	endproperty
	a_push_room: assert property (p_push_room) else $error("push without room");

endmodule
